@@ sv/cbbu_pkg.sv @@
package cbbu_pkg;

  localparam int unsigned MEM_COLUMN = 6;

  localparam logic [7:0] FLAG_S = 8'h80;
  localparam logic [7:0] FLAG_Z = 8'h40;
  localparam logic [7:0] FLAG_H = 8'h10;
  localparam logic [7:0] FLAG_P = 8'h04;
  localparam logic [7:0] FLAG_C = 8'h01;

  typedef enum logic [1:0] {
    QTR_SHIFT = 2'd0,
    QTR_BIT   = 2'd1,
    QTR_RES   = 2'd2,
    QTR_SET   = 2'd3
  } quarter_t;

  typedef enum logic [2:0] {
    OP_RLC = 3'd0,
    OP_RRC = 3'd1,
    OP_RL  = 3'd2,
    OP_RR  = 3'd3,
    OP_SLA = 3'd4,
    OP_SRA = 3'd5,
    OP_SLL = 3'd6,
    OP_SRL = 3'd7
  } shift_op_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  operand;
    logic        carry_in;
    logic        indexed;
    logic [15:0] base_pointer;
    logic [7:0]  displacement;
  } cb_in_t;

  typedef struct packed {
    logic [7:0]  result;
    logic [7:0]  flags;
    logic        flags_written;
    logic        write_back;
    logic        uses_memory;
    logic [15:0] mem_address;
    logic [2:0]  target_register;
    logic        undefined_op;
  } cb_out_t;

  // sign, zero and even parity flags of a byte
  function automatic logic [7:0] szp_flags(input logic [7:0] v);
    logic [7:0] f;
    f = 8'h00;
    if (v[7]) f = f | FLAG_S;
    if (v == 8'h00) f = f | FLAG_Z;
    if (!(^v)) f = f | FLAG_P;
    return f;
  endfunction

endpackage

@@ sv/cbbu_exec.sv @@
module cbbu_exec (
  input  cbbu_pkg::cb_in_t  ins,
  output cbbu_pkg::cb_out_t outs
);

  cbbu_pkg::quarter_t  quarter;
  cbbu_pkg::shift_op_t shift_op;
  logic [2:0]  row;
  logic [2:0]  col;
  logic [7:0]  mask;
  logic [15:0] disp_ext;
  logic [15:0] idx_addr;
  logic        col_mem;
  logic        undef;
  logic [7:0]  sh_res;
  logic        sh_co;
  logic [7:0]  bit_val;

  assign quarter  = cbbu_pkg::quarter_t'(ins.opcode[7:6]);
  assign row      = ins.opcode[5:3];
  assign col      = ins.opcode[2:0];
  assign shift_op = cbbu_pkg::shift_op_t'(row);
  assign mask     = 8'h01 << row;
  assign disp_ext = {{8{ins.displacement[7]}}, ins.displacement};
  assign idx_addr = ins.base_pointer + disp_ext;
  assign col_mem  = (col == 3'(cbbu_pkg::MEM_COLUMN));
  assign undef    = ins.indexed && (quarter != cbbu_pkg::QTR_BIT) && !col_mem;
  assign bit_val  = ins.operand & mask;

  always_comb begin
    unique case (shift_op)
      cbbu_pkg::OP_RLC: begin
        sh_co  = ins.operand[7];
        sh_res = {ins.operand[6:0], ins.operand[7]};
      end
      cbbu_pkg::OP_RRC: begin
        sh_co  = ins.operand[0];
        sh_res = {ins.operand[0], ins.operand[7:1]};
      end
      cbbu_pkg::OP_RL: begin
        sh_co  = ins.operand[7];
        sh_res = {ins.operand[6:0], ins.carry_in};
      end
      cbbu_pkg::OP_RR: begin
        sh_co  = ins.operand[0];
        sh_res = {ins.carry_in, ins.operand[7:1]};
      end
      cbbu_pkg::OP_SLA: begin
        sh_co  = ins.operand[7];
        sh_res = {ins.operand[6:0], 1'b0};
      end
      cbbu_pkg::OP_SRA: begin
        sh_co  = ins.operand[0];
        sh_res = {ins.operand[7], ins.operand[7:1]};
      end
      cbbu_pkg::OP_SLL: begin
        sh_co  = ins.operand[7];
        sh_res = {ins.operand[6:0], 1'b1};
      end
      default: begin
        sh_co  = ins.operand[0];
        sh_res = {1'b0, ins.operand[7:1]};
      end
    endcase
  end

  always_comb begin
    outs.result          = ins.operand;
    outs.flags           = 8'h00;
    outs.flags_written   = 1'b0;
    outs.write_back      = 1'b0;
    outs.target_register = col;
    outs.undefined_op    = undef;
    outs.uses_memory     = 1'b0;
    outs.mem_address     = 16'h0000;

    if (ins.indexed) begin
      if (!undef) begin
        outs.uses_memory = 1'b1;
        outs.mem_address = idx_addr;
      end
    end else if (col_mem) begin
      outs.uses_memory = 1'b1;
      outs.mem_address = ins.base_pointer;
    end

    if (!undef) begin
      unique case (quarter)
        cbbu_pkg::QTR_SHIFT: begin
          outs.result        = sh_res;
          outs.flags         = cbbu_pkg::szp_flags(sh_res) | {7'b0, sh_co};
          outs.flags_written = 1'b1;
          outs.write_back    = 1'b1;
        end
        cbbu_pkg::QTR_BIT: begin
          outs.flags = cbbu_pkg::szp_flags(bit_val) | cbbu_pkg::FLAG_H
                       | {7'b0, ins.carry_in};
          outs.flags_written = 1'b1;
        end
        cbbu_pkg::QTR_RES: begin
          outs.result     = ins.operand & ~mask;
          outs.write_back = 1'b1;
        end
        default: begin
          outs.result     = ins.operand | mask;
          outs.write_back = 1'b1;
        end
      endcase
    end
  end

endmodule

@@ sv/z80_cb_group_bit_unit_core.sv @@
// Channel  | Ports                                              | Handshake
// ---------+----------------------------------------------------+---------------------
// command  | opcode operand carry_in indexed base_pointer        | start & !busy
//          | displacement                                       |
// result   | result flags flags_written write_back uses_memory  | done, one cycle
//          | mem_address target_register undefined_op           |
//
// One transaction per clock; busy never rises. The command is captured in
// the input register, decoded and executed in one pass, and loaded into the
// result register, which drives done.
// rst (synchronous) clears both valid bits; nothing else needs reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module z80_cb_group_bit_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  opcode,
  input  logic [7:0]  operand,
  input  logic        carry_in,
  input  logic        indexed,
  input  logic [15:0] base_pointer,
  input  logic [7:0]  displacement,
  output logic        done,
  output logic [7:0]  result,
  output logic [7:0]  flags,
  output logic        flags_written,
  output logic        write_back,
  output logic        uses_memory,
  output logic [15:0] mem_address,
  output logic [2:0]  target_register,
  output logic        undefined_op
);

  cbbu_pkg::cb_in_t  in_reg;
  logic              in_valid;
  cbbu_pkg::cb_out_t exec_out;
  cbbu_pkg::cb_out_t out_reg;
  logic              out_valid;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_valid  <= start && !busy;
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_reg <= '{opcode:       opcode,
                  operand:      operand,
                  carry_in:     carry_in,
                  indexed:      indexed,
                  base_pointer: base_pointer,
                  displacement: displacement};
    end
    if (in_valid) begin
      out_reg <= exec_out;
    end
  end

  cbbu_exec u_exec (
    .ins  (in_reg),
    .outs (exec_out)
  );

  assign done            = out_valid;
  assign result          = out_reg.result;
  assign flags           = out_reg.flags;
  assign flags_written   = out_reg.flags_written;
  assign write_back      = out_reg.write_back;
  assign uses_memory     = out_reg.uses_memory;
  assign mem_address     = out_reg.mem_address;
  assign target_register = out_reg.target_register;
  assign undefined_op    = out_reg.undefined_op;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RANDOM_ITEMS   = 900;
  localparam int unsigned TAIL_CYCLES    = 8;

  typedef struct {
    cbbu_pkg::cb_in_t cmd;
    bit               drain;     // hold off until all outstanding results are back
    int unsigned      idle_pct;
  } cmd_slot_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [7:0]  opcode = '0;
  logic [7:0]  operand = '0;
  logic        carry_in = 1'b0;
  logic        indexed = 1'b0;
  logic [15:0] base_pointer = '0;
  logic [7:0]  displacement = '0;
  logic        busy;
  logic        done;
  logic [7:0]  result;
  logic [7:0]  flags;
  logic        flags_written;
  logic        write_back;
  logic        uses_memory;
  logic [15:0] mem_address;
  logic [2:0]  target_register;
  logic        undefined_op;

  cmd_slot_t          cmd_q[$];
  cbbu_pkg::cb_out_t  cb_outcome_q[$];
  cbbu_pkg::cb_in_t   cur_cmd;
  cmd_slot_t          next_slot;
  int unsigned        error_count = 0;
  int unsigned        quiet_cycles = 0;

  z80_cb_group_bit_unit_core dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .operand         (operand),
    .carry_in        (carry_in),
    .indexed         (indexed),
    .base_pointer    (base_pointer),
    .displacement    (displacement),
    .done            (done),
    .result          (result),
    .flags           (flags),
    .flags_written   (flags_written),
    .write_back      (write_back),
    .uses_memory     (uses_memory),
    .mem_address     (mem_address),
    .target_register (target_register),
    .undefined_op    (undefined_op)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // sign, zero and even-parity bits of a byte
  function automatic logic [7:0] sz_parity(input logic [7:0] v);
    logic [7:0] f;
    int unsigned ones;
    f = 8'h00;
    ones = 0;
    for (int i = 0; i < 8; i++) ones += v[i];
    if (v[7]) f |= cbbu_pkg::FLAG_S;
    if (v == 8'h00) f |= cbbu_pkg::FLAG_Z;
    if (ones % 2 == 0) f |= cbbu_pkg::FLAG_P;
    return f;
  endfunction

  function automatic cbbu_pkg::cb_out_t cb_execute(input cbbu_pkg::cb_in_t c);
    cbbu_pkg::cb_out_t  o;
    cbbu_pkg::quarter_t qtr;
    logic [2:0] row;
    logic [7:0] mask;
    logic [7:0] v;
    logic       co;
    qtr  = cbbu_pkg::quarter_t'(c.opcode[7:6]);
    row  = c.opcode[5:3];
    mask = 8'h01 << row;
    v    = c.operand;
    co   = 1'b0;
    o    = '0;
    o.result          = v;
    o.target_register = c.opcode[2:0];
    if (c.indexed) begin
      if (qtr != cbbu_pkg::QTR_BIT && c.opcode[2:0] != 3'(cbbu_pkg::MEM_COLUMN)) begin
        o.undefined_op = 1'b1;
      end else begin
        o.uses_memory = 1'b1;
        o.mem_address = c.base_pointer + {{8{c.displacement[7]}}, c.displacement};
      end
    end else if (c.opcode[2:0] == 3'(cbbu_pkg::MEM_COLUMN)) begin
      o.uses_memory = 1'b1;
      o.mem_address = c.base_pointer;
    end
    if (!o.undefined_op) begin
      case (qtr)
        cbbu_pkg::QTR_SHIFT: begin
          case (cbbu_pkg::shift_op_t'(row))
            cbbu_pkg::OP_RLC: {co, o.result} = {v, v[7]};
            cbbu_pkg::OP_RRC: {o.result, co} = {v[0], v};
            cbbu_pkg::OP_RL:  {co, o.result} = {v, c.carry_in};
            cbbu_pkg::OP_RR:  {o.result, co} = {c.carry_in, v};
            cbbu_pkg::OP_SLA: {co, o.result} = {v, 1'b0};
            cbbu_pkg::OP_SRA: {o.result, co} = {v[7], v};
            cbbu_pkg::OP_SLL: {co, o.result} = {v, 1'b1};
            default:          {o.result, co} = {1'b0, v};
          endcase
          o.flags         = sz_parity(o.result) | (co ? cbbu_pkg::FLAG_C : 8'h00);
          o.flags_written = 1'b1;
          o.write_back    = 1'b1;
        end
        cbbu_pkg::QTR_BIT: begin
          o.flags         = sz_parity(v & mask) | cbbu_pkg::FLAG_H
                            | (c.carry_in ? cbbu_pkg::FLAG_C : 8'h00);
          o.flags_written = 1'b1;
        end
        cbbu_pkg::QTR_RES: begin
          o.result     = v & ~mask;
          o.write_back = 1'b1;
        end
        default: begin
          o.result     = v | mask;
          o.write_back = 1'b1;
        end
      endcase
    end
    return o;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic add_cmd(input logic [7:0] op, input logic [7:0] val, input logic cin,
                         input logic idx, input logic [15:0] base,
                         input logic [7:0] disp, input bit drain,
                         input int unsigned idle_pct);
    cmd_slot_t s;
    s.cmd      = '{op, val, cin, idx, base, disp};
    s.drain    = drain;
    s.idle_pct = idle_pct;
    cmd_q.push_back(s);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) cb_outcome_q.push_back(cb_execute(cur_cmd));
      if (start && busy) begin
        // command not taken yet, hold it
      end else if (cmd_q.size() != 0 &&
                   !(cmd_q[0].drain && cb_outcome_q.size() != 0) &&
                   $urandom_range(99) >= cmd_q[0].idle_pct) begin
        next_slot = cmd_q.pop_front();
        cur_cmd   = next_slot.cmd;
        {opcode, operand, carry_in, indexed, base_pointer, displacement} <= next_slot.cmd;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cbbu_pkg::cb_out_t want;
    if (!rst && done) begin
      if (cb_outcome_q.size() == 0) begin
        report("result with no transaction outstanding");
      end else begin
        want = cb_outcome_q.pop_front();
        check_field("result", 16'(result), 16'(want.result));
        check_field("flags", 16'(flags), 16'(want.flags));
        check_field("flags_written", 16'(flags_written), 16'(want.flags_written));
        check_field("write_back", 16'(write_back), 16'(want.write_back));
        check_field("uses_memory", 16'(uses_memory), 16'(want.uses_memory));
        check_field("mem_address", mem_address, want.mem_address);
        check_field("target_register", 16'(target_register),
                    16'(want.target_register));
        check_field("undefined_op", 16'(undefined_op), 16'(want.undefined_op));
      end
    end
  end

  // watchdog: cycles with neither a command nor a result taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      phase_idle[4];
    int unsigned      idle;
    cbbu_pkg::cb_in_t c;
    phase_idle = '{0, 52, 0, 17};

    // directed: every shift op, BIT/RES/SET corner cases, address forms
    add_cmd(8'h00, 8'h80, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // RLC B
    add_cmd(8'h09, 8'h01, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // RRC C
    add_cmd(8'h12, 8'h80, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // RL D
    add_cmd(8'h1B, 8'h01, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // RR E
    add_cmd(8'h24, 8'hFF, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // SLA H
    add_cmd(8'h2D, 8'h81, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // SRA L
    add_cmd(8'h37, 8'h00, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // SLL A
    add_cmd(8'h3E, 8'h01, 1'b0, 1'b0, 16'h1234, 8'h00, 1'b0, 0);  // SRL (HL)
    add_cmd(8'h3F, 8'h00, 1'b0, 1'b0, 16'hFFFF, 8'hFF, 1'b0, 0);  // SRL A, result zero
    add_cmd(8'h40, 8'hFE, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // BIT 0, tested bit clear
    add_cmd(8'h7F, 8'h80, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // BIT 7, sign
    add_cmd(8'h7E, 8'hFF, 1'b0, 1'b0, 16'hABCD, 8'h00, 1'b0, 0);  // BIT 7,(HL)
    add_cmd(8'h80, 8'hFF, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // RES 0
    add_cmd(8'hBE, 8'hFF, 1'b1, 1'b0, 16'h8000, 8'h00, 1'b0, 0);  // RES 7,(HL)
    add_cmd(8'hC0, 8'h00, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // SET 0
    add_cmd(8'hFF, 8'h7F, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b0, 0);  // SET 7
    add_cmd(8'hDE, 8'h00, 1'b0, 1'b0, 16'hFFFF, 8'h55, 1'b0, 0);  // displacement ignored
    add_cmd(8'h01, 8'hAA, 1'b0, 1'b0, 16'hFFFF, 8'h7F, 1'b0, 0);  // plain, register column
    add_cmd(8'hFE, 8'h00, 1'b0, 1'b1, 16'hFFFF, 8'h01, 1'b0, 0);  // indexed wrap up
    add_cmd(8'h06, 8'h80, 1'b1, 1'b1, 16'h0000, 8'h80, 1'b0, 0);  // indexed wrap down
    add_cmd(8'h46, 8'h01, 1'b1, 1'b1, 16'h1000, 8'h7F, 1'b0, 0);  // indexed BIT col 6
    add_cmd(8'h40, 8'h00, 1'b0, 1'b1, 16'h2000, 8'h80, 1'b0, 0);  // indexed BIT col 0
    add_cmd(8'h00, 8'h5A, 1'b1, 1'b1, 16'h3000, 8'h10, 1'b0, 0);  // indexed undefined shift
    add_cmd(8'h87, 8'hFF, 1'b0, 1'b1, 16'hFFFF, 8'hFF, 1'b0, 0);  // indexed undefined RES
    add_cmd(8'hFD, 8'h00, 1'b1, 1'b1, 16'h7FFF, 8'h01, 1'b0, 0);  // indexed undefined SET

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      idle = phase_idle[n / (RANDOM_ITEMS / 4)];
      c.opcode       = 8'($urandom_range(255));
      c.carry_in     = 1'($urandom_range(1));
      c.indexed      = 1'($urandom_range(1));
      c.base_pointer = 16'($urandom_range(16'hFFFF));
      c.displacement = 8'($urandom_range(255));
      case ($urandom_range(7))
        0:       c.operand = 8'h00;
        1:       c.operand = 8'hFF;
        2:       c.operand = $urandom_range(1) ? 8'h80 : 8'h01;
        default: c.operand = 8'($urandom_range(255));
      endcase
      // most indexed commands are well formed; the rest are undefined unless BIT or column 6
      if (c.indexed && $urandom_range(9) < 7) c.opcode[2:0] = 3'(cbbu_pkg::MEM_COLUMN);
      add_cmd(c.opcode, c.operand, c.carry_in, c.indexed, c.base_pointer,
              c.displacement, (n % (RANDOM_ITEMS / 4) == 0) || ($urandom_range(99) == 0),
              idle);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start || cb_outcome_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    while (cb_outcome_q.size() != 0) begin
      void'(cb_outcome_q.pop_front());
      report("expected result never arrived");
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
